// File: rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the serial frame receiver
// Holds the header bytes, the item kind codes and the result item struct that
// travels from the front end through the queue to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    // header sync bytes and register reset value
    localparam logic [7:0] SYNC_FIRST        = 8'h55;
    localparam logic [7:0] SYNC_SECOND       = 8'hAA;
    localparam logic [7:0] OWN_ADDRESS_RESET = 8'hFE;

    // number of bytes kept for the header search
    localparam int HIST_DEPTH = 5;

    // result item kinds
    localparam logic KIND_BODY = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // width of the packed output beat, whole bytes
    localparam int OUT_FIELDS_W = 33;
    localparam int OUT_TDATA_W  = 40;

    // one classified result item
    typedef struct packed {
        logic       item_kind;
        logic [7:0] body_byte;
        logic [7:0] body_index;
        logic       frame_good;
        logic [7:0] frame_command;
        logic [7:0] frame_length;
    } t_sfr_item;

endpackage

`default_nettype wire

// File: rtl/core/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front: byte intake and frame tracking
// Keeps the byte history, matches the header, follows the body and checksum
// and pushes one classified result item per accepted body or checksum byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  wire [7:0]            i_cfg_wr_data,
    input  wire                  i_accept,
    input  wire [7:0]            i_rx_byte,
    output logic                 o_push,
    output sfr_pkg::t_sfr_item   o_item
);
    import sfr_pkg::*;

    logic [7:0] r_own_address;
    logic [7:0] r_hist [HIST_DEPTH];
    logic       r_in_frame,   n_in_frame;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_sum,        n_sum;
    logic [7:0] r_body_count, n_body_count;
    logic [7:0] r_command,    n_command;
    logic       hdr_match;

    // header seen in the five previous bytes
    assign hdr_match = (r_hist[0] == SYNC_FIRST) && (r_hist[1] == SYNC_SECOND) &&
                       (r_hist[2] == r_own_address) && (r_hist[4] != 8'd0);

    // classify the byte and work out the next frame state
    always_comb begin
        n_in_frame   = r_in_frame;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_body_count = r_body_count;
        n_command    = r_command;
        o_push       = 1'b0;
        o_item       = '0;
        if (!r_in_frame) begin
            if (hdr_match) begin
                n_in_frame       = 1'b1;
                n_command        = i_rx_byte;
                n_sum            = i_rx_byte;
                n_body_count     = 8'd1;
                n_bytes_left     = r_hist[4] - 8'd1;
                o_push           = i_accept;
                o_item.item_kind = KIND_BODY;
                o_item.body_byte = i_rx_byte;
            end
        end else if (r_bytes_left != 8'd0) begin
            n_sum             = r_sum + i_rx_byte;
            n_body_count      = r_body_count + 8'd1;
            n_bytes_left      = r_bytes_left - 8'd1;
            o_push            = i_accept;
            o_item.item_kind  = KIND_BODY;
            o_item.body_byte  = i_rx_byte;
            o_item.body_index = r_body_count;
        end else begin
            n_in_frame           = 1'b0;
            o_push               = i_accept;
            o_item.item_kind     = KIND_END;
            o_item.frame_good    = (~r_sum == i_rx_byte);
            o_item.frame_command = r_command;
            o_item.frame_length  = r_body_count;
        end
    end

    // own address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= OWN_ADDRESS_RESET;
        end else if (i_cfg_wr_en) begin
            r_own_address <= i_cfg_wr_data;
        end
    end

    // frame state and history, advanced on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= 8'd0;
            end
            r_in_frame   <= 1'b0;
            r_bytes_left <= 8'd0;
            r_sum        <= 8'd0;
            r_body_count <= 8'd0;
            r_command    <= 8'd0;
        end else if (i_accept) begin
            for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                r_hist[i] <= r_hist[i + 1];
            end
            r_hist[HIST_DEPTH - 1] <= i_rx_byte;
            r_in_frame   <= n_in_frame;
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
            r_body_count <= n_body_count;
            r_command    <= n_command;
        end
    end

    // an end report comes only from the checksum byte of an open frame
    a_end_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && (o_item.item_kind == KIND_END) |-> r_in_frame && (r_bytes_left == 8'd0))
        else $error("end report outside a frame");

    // an open frame has counted at least its command byte
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_body_count != 8'd0))
        else $error("open frame with empty body count");

endmodule

`default_nettype wire

// File: rtl/core/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue: result item queue between front end and output stage
// Small register queue, fill count; one push unless full, one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_queue #(
    parameter int DEPTH = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire sfr_pkg::t_sfr_item i_item,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_valid,
    output sfr_pkg::t_sfr_item   o_item
);
    import sfr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_sfr_item           r_store [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_store[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage write
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // the front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    // a lone push grows the fill count by one
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("fill count did not follow push");

    // a lone pop shrinks the fill count by one
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop && !do_push |=> r_count == $past(r_count) - 1'b1)
        else $error("fill count did not follow pop");

endmodule

`default_nettype wire

// File: rtl/core/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back: output register stage
// Takes items from the queue into the output register and packs them into
// the output beat; refills in the same cycle that a beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_valid,
    input  wire sfr_pkg::t_sfr_item      i_q_item,
    output logic                         o_q_pop,
    output logic                         o_tvalid,
    input  wire                          i_tready,
    output logic [sfr_pkg::OUT_TDATA_W-1:0] o_tdata,
    output logic [0:0]                   o_tuser
);
    import sfr_pkg::*;

    logic      r_valid;
    t_sfr_item r_item;

    // load when the register is empty or its beat leaves now
    assign o_q_pop = i_q_valid && (!r_valid || i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_tready) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
    end

    // pack fields from the lowest bit up
    assign o_tvalid = r_valid;
    assign o_tuser  = r_item.item_kind;
    assign o_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                       r_item.frame_length, r_item.frame_command, r_item.frame_good,
                       r_item.body_index, r_item.body_byte};

endmodule

`default_nettype wire

// File: rtl/core/serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver: header, length and checksum deframer
// Finds frames in a received byte stream, reports every body byte with its
// index and an end report with command, length and checksum result.
//
//   channel   dir  beat contents
//   s_axis    in   tdata[7:0] rx_byte
//   m_axis    out  tuser[0] item_kind; tdata body_byte, body_index,
//                  frame_good, frame_command, frame_length
//   cfg       in   own_address, written when i_cfg_wr_en is high
//
// One byte is taken per cycle unless the queue is full; header compare, running
// sum and counters settle in that cycle. Results pass queue and output stage.
// Reset is synchronous; own_address returns to 0xFE and the search restarts.
// s_axis_tready drops only when the result queue (QUEUE_DEPTH items) is full;
// with the output register also holding one, a stalled m_axis holds the input
// back after QUEUE_DEPTH + 1 results.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_wr_en,
    input  wire  [7:0]                    i_cfg_wr_data,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire  [7:0]                    s_axis_tdata,  // [7:0] rx_byte
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // [7:0] body_byte, [15:8] body_index, [16] frame_good,
    // [24:17] frame_command, [32:25] frame_length, [39:33] zero
    output logic [sfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]                    m_axis_tuser   // [0] item_kind
);
    import sfr_pkg::*;

    logic      accept;
    logic      push;
    t_sfr_item push_item;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    t_sfr_item q_item;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // front end: header search and frame tracking
    sfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_rx_byte     (s_axis_tdata),
        .o_push        (push),
        .o_item        (push_item)
    );

    // queue between the two sides
    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // output register stage
    sfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser)
    );

endmodule

`default_nettype wire
